// ===== rtl/slcsfp_pkg.sv =====
// ----------------------------------------------------------------------------
// slcsfp_pkg
// Shared constants and types for the sync/length/command/sum frame parser.
// ----------------------------------------------------------------------------
package slcsfp_pkg;

   localparam int MAX_PAYLOAD = 64;
   localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
   localparam int IDX_W       = $clog2(MAX_PAYLOAD);
   localparam int BYTE_W      = 8;

   localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hAA;
   localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h55;

   typedef enum logic [2:0] {
      ST_HUNT1,
      ST_HUNT2,
      ST_LEN,
      ST_CMD,
      ST_PAYLOAD,
      ST_CHECK,
      ST_READ,
      ST_SEND
   } state_type;

endpackage

// ===== rtl/slcsfp_req_if.sv =====
// ----------------------------------------------------------------------------
// slcsfp_req_if
// Received-byte channel: valid/ready handshake, one byte per word.
// ----------------------------------------------------------------------------
interface slcsfp_req_if
   import slcsfp_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/slcsfp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// slcsfp_rsp_if
// Frame result channel: valid/ready handshake, one payload byte per word.
// ----------------------------------------------------------------------------
interface slcsfp_rsp_if
   import slcsfp_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] command;
   logic [LEN_W-1:0]  frame_length;
   logic [IDX_W-1:0]  byte_index;
   logic [BYTE_W-1:0] payload_byte;
   logic              empty_frame;
   logic              last_of_frame;

   modport source (output valid, output command, output frame_length,
                   output byte_index, output payload_byte, output empty_frame,
                   output last_of_frame, input ready);
   modport sink   (input valid, input command, input frame_length,
                   input byte_index, input payload_byte, input empty_frame,
                   input last_of_frame, output ready);
endinterface

// ===== rtl/sync_len_cmd_sum_frame_parser.sv =====
// ----------------------------------------------------------------------------
// sync_len_cmd_sum_frame_parser
// Hunts for sync AA 55, reads length, command, payload into a 64x8 buffer and
// checks an 8-bit additive sum; on a match replays the buffer, one word each.
// ----------------------------------------------------------------------------
// Output path: a good check byte of an empty frame loads the output register at once;
//   otherwise replay passes ST_READ and ST_SEND before its first word is loaded.
// Throughput: 1 input byte per cycle while parsing, the check byte only with a free
//   output register; replay: buffer read, then output load per word, input held off.
// Reset: synchronous; parser returns to sync hunt, output register empties.
//   Buffer contents are not cleared.
module sync_len_cmd_sum_frame_parser
   import slcsfp_pkg::*;
(
   input logic          clock,
   input logic          reset,
   slcsfp_req_if.sink   req_ch,
   slcsfp_rsp_if.source rsp_ch
);

   state_type         state_ff, state_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [BYTE_W-1:0] cmd_ff, cmd_in;
   logic [LEN_W-1:0]  fill_ff, fill_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [BYTE_W-1:0] rd_data_ff;
   logic [BYTE_W-1:0] mem [MAX_PAYLOAD];
   logic              mem_we;

   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_cmd_ff;
   logic [LEN_W-1:0]  out_len_ff;
   logic [IDX_W-1:0]  out_idx_ff, out_idx_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              out_empty_ff, out_empty_in;
   logic              out_last_ff, out_last_in;
   logic              out_load;

   logic              req_fire;
   logic              out_free;
   logic [BYTE_W-1:0] rx;
   logic [BYTE_W-1:0] sum_add;
   logic [LEN_W-1:0]  fill_next;

   assign rx       = req_ch.rx_byte;
   assign req_fire = req_ch.valid && req_ch.ready;
   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign sum_add  = sum_ff + rx;
   assign fill_next = fill_ff + LEN_W'(1);

   always_comb begin
      case (state_ff)
         ST_HUNT1, ST_HUNT2, ST_LEN, ST_CMD, ST_PAYLOAD: begin
            req_ch.ready = 1'b1;
         end
         ST_CHECK: begin
            req_ch.ready = out_free;
         end
         default: begin
            req_ch.ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      cmd_in       = cmd_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      rd_idx_in    = rd_idx_ff;
      mem_we       = 1'b0;
      out_load     = 1'b0;
      out_idx_in   = out_idx_ff;
      out_byte_in  = out_byte_ff;
      out_empty_in = out_empty_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         ST_HUNT1: begin
            if (req_fire && rx == SYNC_FIRST) state_in = ST_HUNT2;
         end
         ST_HUNT2: begin
            if (req_fire) begin
               if (rx == SYNC_SECOND)     state_in = ST_LEN;
               else if (rx == SYNC_FIRST) state_in = ST_HUNT2;
               else                       state_in = ST_HUNT1;
            end
         end
         ST_LEN: begin
            if (req_fire) begin
               if (rx > BYTE_W'(MAX_PAYLOAD)) begin
                  state_in = ST_HUNT1;
               end else begin
                  len_in   = LEN_W'(rx);
                  sum_in   = rx;
                  state_in = ST_CMD;
               end
            end
         end
         ST_CMD: begin
            if (req_fire) begin
               cmd_in   = rx;
               sum_in   = sum_add;
               fill_in  = '0;
               state_in = (len_ff != '0) ? ST_PAYLOAD : ST_CHECK;
            end
         end
         ST_PAYLOAD: begin
            if (req_fire) begin
               mem_we  = 1'b1;
               fill_in = fill_next;
               sum_in  = sum_add;
               if (fill_next >= len_ff) state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (req_fire) begin
               state_in = ST_HUNT1;
               if (sum_ff == rx) begin
                  if (len_ff == '0) begin
                     out_load     = 1'b1;
                     out_idx_in   = '0;
                     out_byte_in  = '0;
                     out_empty_in = 1'b1;
                     out_last_in  = 1'b1;
                  end else begin
                     rd_idx_in = '0;
                     state_in  = ST_READ;
                  end
               end
            end
         end
         ST_READ: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (out_free) begin
               out_load     = 1'b1;
               out_idx_in   = rd_idx_ff;
               out_byte_in  = rd_data_ff;
               out_empty_in = 1'b0;
               out_last_in  = (LEN_W'(rd_idx_ff) + LEN_W'(1)) == len_ff;
               if (out_last_in) begin
                  state_in = ST_HUNT1;
               end else begin
                  rd_idx_in = rd_idx_ff + IDX_W'(1);
                  state_in  = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_HUNT1;
         end
      endcase
   end

   assign out_valid_in = out_load ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_HUNT1;
         len_ff       <= '0;
         cmd_ff       <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         rd_idx_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         cmd_ff       <= cmd_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         rd_idx_ff    <= rd_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload buffer: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) mem[fill_ff[IDX_W-1:0]] <= rx;
      rd_data_ff <= mem[rd_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_cmd_ff   <= cmd_ff;
         out_len_ff   <= len_ff;
         out_idx_ff   <= out_idx_in;
         out_byte_ff  <= out_byte_in;
         out_empty_ff <= out_empty_in;
         out_last_ff  <= out_last_in;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.command       = out_cmd_ff;
   assign rsp_ch.frame_length  = out_len_ff;
   assign rsp_ch.byte_index    = out_idx_ff;
   assign rsp_ch.payload_byte  = out_byte_ff;
   assign rsp_ch.empty_frame   = out_empty_ff;
   assign rsp_ch.last_of_frame = out_last_ff;

endmodule
